// ===== rtl/qau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

  localparam int CW       = 16;            // component width
  localparam int FB       = 13;            // fraction bits
  localparam int CFG_W    = 15;            // min_norm_sq width
  localparam int PW       = 2 * CW;        // first-layer product
  localparam int P2W      = 2 * CW + 1;    // second-layer product (conj operand is one bit wider)
  localparam int SW       = 2 * CW + 3;    // sum of four products
  localparam int NW       = 2 * CW - FB + 1; // squared norm
  localparam int MW       = CW + FB;       // inverse dividend
  localparam int DIV_STEP = 2;             // quotient bits per divider stage
  localparam int DIV_ST   = (CW + DIV_STEP - 1) / DIV_STEP;

  typedef logic signed [CW-1:0] comp_t;

  typedef enum logic [2:0] {
    OP_MUL   = 3'd0,
    OP_ROT   = 3'd1,
    OP_CONJ  = 3'd2,
    OP_INV   = 3'd3,
    OP_ADD   = 3'd4,
    OP_SCALE = 3'd5,
    OP_DOT   = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_ZDIV = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t opcode;
    comp_t   a_i;
    comp_t   a_j;
    comp_t   a_k;
    comp_t   a_r;
    comp_t   b_i;
    comp_t   b_j;
    comp_t   b_k;
    comp_t   b_r;
  } cmd_t;

  typedef struct packed {
    comp_t   res_i;
    comp_t   res_j;
    comp_t   res_k;
    comp_t   res_r;
    status_t status;
  } rsp_t;

  typedef struct packed {
    comp_t v;
    logic  ovf;
  } sat_t;

  // Hamilton product: row r, column c uses a[c] * b[HP_PICK[r][c]], negated where HP_NEG
  localparam bit HP_NEG [4][4] = '{
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b1, 1'b0}
  };
  localparam logic [1:0] HP_PICK [4][4] = '{
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd0, 2'd1, 2'd2, 2'd3}
  };

  localparam logic signed [SW:0] SMAX = {{(SW+2-CW){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW:0] SMIN = {{(SW+2-CW){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [SW:0] HALF = {{(SW+1-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam comp_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam comp_t CMIN = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [SW-1:0] ext_p(input logic signed [PW-1:0] p);
    return $signed({{(SW-PW){p[PW-1]}}, p});
  endfunction

  function automatic logic signed [SW-1:0] ext_x(input logic signed [P2W-1:0] p);
    return $signed({{(SW-P2W){p[P2W-1]}}, p});
  endfunction

  function automatic logic signed [SW:0] ext_c(input comp_t x);
    return $signed({{(SW+1-CW){x[CW-1]}}, x});
  endfunction

  function automatic sat_t sat_ext(input logic signed [SW:0] t);
    sat_t r;
    if (t > SMAX) begin
      r.v   = CMAX;
      r.ovf = 1'b1;
    end else if (t < SMIN) begin
      r.v   = CMIN;
      r.ovf = 1'b1;
    end else begin
      r.v   = t[CW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // round to nearest, ties up, then saturate
  function automatic sat_t round_sat(input logic signed [SW-1:0] s);
    logic signed [SW:0] t;
    t = $signed({s[SW-1], s}) + HALF;
    t = t >>> FB;
    return sat_ext(t);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qau_div_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-lane restoring divider for the inverse: |cv| * 2^FB / n, two quotient
// bits per stage, saturating signed result.
module qau_div_pipe import qau_pkg::*; (
  input  logic              clk,
  input  logic [DIV_ST:0]   en,
  input  logic [CW-1:0]     mag [4],
  input  logic [3:0]        neg,
  input  logic [NW-1:0]     n,
  output comp_t             quot [4],
  output logic              ovf
);

  logic [NW-1:0] dn  [DIV_ST+1];
  logic [NW-1:0] rem [DIV_ST+1][4];
  logic [CW-1:0] ql  [DIV_ST+1][4];
  logic [CW-1:0] dl  [DIV_ST+1][4];
  logic          big [DIV_ST+1][4];
  logic          sgn [DIV_ST+1][4];

  logic [NW-1:0] rn [1:DIV_ST][4];
  logic [CW-1:0] qn [1:DIV_ST][4];

  logic [MW-1:0]    dvd [4];
  logic [MW+NW-1:0] lim;

  always_comb begin
    lim = (MW+NW)'({n, {CW{1'b0}}});
    for (int l = 0; l < 4; l++) begin
      dvd[l] = {mag[l], {FB{1'b0}}};
    end
  end

  always_comb begin
    logic [NW-1:0] r;
    logic [NW:0]   r2;
    logic [CW-1:0] qq;
    int            idx;
    for (int s = 1; s <= DIV_ST; s++) begin
      for (int l = 0; l < 4; l++) begin
        r  = rem[s-1][l];
        qq = ql[s-1][l];
        for (int k = 0; k < DIV_STEP; k++) begin
          idx = CW - 1 - (DIV_STEP * (s - 1) + k);
          if (idx >= 0) begin
            r2 = {r, dl[s-1][l][idx]};
            if (r2 >= {1'b0, dn[s-1]}) begin
              r2      = r2 - {1'b0, dn[s-1]};
              qq[idx] = 1'b1;
            end
            r = r2[NW-1:0];
          end
        end
        rn[s][l] = r;
        qn[s][l] = qq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dn[0] <= n;
      for (int l = 0; l < 4; l++) begin
        // quotient of 2^CW or more cannot fit, whatever the sign
        big[0][l] <= (MW+NW)'(dvd[l]) >= lim;
        rem[0][l] <= NW'(dvd[l][MW-1:CW]);
        dl[0][l]  <= dvd[l][CW-1:0];
        ql[0][l]  <= '0;
        sgn[0][l] <= neg[l];
      end
    end
    for (int s = 1; s <= DIV_ST; s++) begin
      if (en[s]) begin
        dn[s] <= dn[s-1];
        for (int l = 0; l < 4; l++) begin
          big[s][l] <= big[s-1][l];
          rem[s][l] <= rn[s][l];
          dl[s][l]  <= dl[s-1][l];
          ql[s][l]  <= qn[s][l];
          sgn[s][l] <= sgn[s-1][l];
        end
      end
    end
  end

  always_comb begin
    logic [CW-1:0] qv;
    logic          o;
    ovf = 1'b0;
    for (int l = 0; l < 4; l++) begin
      qv = ql[DIV_ST][l];
      o  = 1'b0;
      if (big[DIV_ST][l]) begin
        quot[l] = sgn[DIV_ST][l] ? CMIN : CMAX;
        o       = 1'b1;
      end else if (sgn[DIV_ST][l]) begin
        if (qv[CW-1] && (|qv[CW-2:0])) begin
          quot[l] = CMIN;
          o       = 1'b1;
        end else begin
          quot[l] = $signed(-qv);
        end
      end else begin
        if (qv[CW-1]) begin
          quot[l] = CMAX;
          o       = 1'b1;
        end else begin
          quot[l] = $signed(qv);
        end
      end
      ovf = ovf | o;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/quaternion_arithmetic_unit_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake              Carries
// cmd      in   cmd_valid / cmd_stall  cmd_t: opcode, quaternion A, operand B
// rsp      out  rsp_valid / rsp_stall  rsp_t: res_i..res_r, status
// cfg      in   cfg_valid / cfg_ready  min_norm_sq (15 bits), always ready
//
// One transaction per cycle while rsp is not stalled; the pipeline depth is set
// by the divider for the inverse, which takes two quotient bits per stage.
// Every opcode runs the full pipeline so results leave in order.
// Synchronous reset empties the pipe and sets min_norm_sq to 1.
// Stages hold independently: a stall on rsp fills bubbles before cmd stalls.

module quaternion_arithmetic_unit_top import qau_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  cmd_t             cmd,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int NST = DIV_ST + 4;

  logic [NST-1:0]   vld;
  logic [NST-1:0]   adv;
  logic [CFG_W-1:0] min_norm_sq;

  // ---------------- handshake
  assign cfg_ready = 1'b1;
  assign rsp_valid = vld[NST-1];
  assign cmd_stall = !adv[0];

  always_comb begin
    adv[NST-1] = !vld[NST-1] || !rsp_stall;
    for (int s = NST - 2; s >= 0; s--) begin
      adv[s] = !vld[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= '0;
      min_norm_sq <= CFG_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_norm_sq <= cfg_data;
      end
      if (adv[0]) begin
        vld[0] <= cmd_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (adv[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // ---------------- stage 1: sixteen products
  comp_t a_in [4];
  comp_t b_in [4];

  always_comb begin
    a_in = '{cmd.a_i, cmd.a_j, cmd.a_k, cmd.a_r};
    case (cmd.opcode)
      OP_INV:  b_in = a_in;                          // row 3 gives the squares
      OP_ROT:  b_in = '{cmd.b_i, cmd.b_j, cmd.b_k, '0};
      default: b_in = '{cmd.b_i, cmd.b_j, cmd.b_k, cmd.b_r};
    endcase
  end

  opcode_t               s1_op;
  comp_t                 s1_a [4];
  comp_t                 s1_b [4];
  logic signed [PW-1:0]  s1_p [4][4];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_op <= cmd.opcode;
      s1_a  <= a_in;
      s1_b  <= b_in;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          s1_p[r][c] <= a_in[c] * b_in[HP_PICK[r][c]];
        end
      end
    end
  end

  // ---------------- stage 2: sums, rounding, saturation
  logic signed [SW-1:0] ss [4];
  logic signed [SW-1:0] sdot;
  sat_t                 rr [4];
  sat_t                 rdot;
  sat_t                 rsc [4];
  sat_t                 radd [4];
  sat_t                 rneg [4];
  comp_t                res_nx [4];
  logic                 ovf_nx;
  logic [NW-1:0]        n_nx;
  logic signed [CW:0]   cv [4];

  always_comb begin
    sdot = '0;
    for (int r = 0; r < 4; r++) begin
      ss[r] = '0;
      for (int c = 0; c < 4; c++) begin
        if (HP_NEG[r][c]) begin
          ss[r] = ss[r] - ext_p(s1_p[r][c]);
        end else begin
          ss[r] = ss[r] + ext_p(s1_p[r][c]);
        end
      end
      sdot     = sdot + ext_p(s1_p[3][r]);
      rr[r]    = round_sat(ss[r]);
      rsc[r]   = round_sat(ext_p(s1_p[r][r]));   // a[c] * b_r sits on the diagonal
      radd[r]  = sat_ext(ext_c(s1_a[r]) + ext_c(s1_b[r]));
      rneg[r]  = sat_ext(-ext_c(s1_a[r]));
      cv[r]    = (r < 3) ? -$signed({s1_a[r][CW-1], s1_a[r]})
                         : $signed({s1_a[r][CW-1], s1_a[r]});
    end
    rdot = round_sat(sdot);
    n_nx = sdot[FB+NW-1:FB];

    res_nx = '{default: '0};
    ovf_nx = 1'b0;
    case (s1_op)
      OP_MUL: begin
        for (int r = 0; r < 4; r++) begin
          res_nx[r] = rr[r].v;
          ovf_nx    = ovf_nx | rr[r].ovf;
        end
      end
      OP_ROT: begin
        for (int r = 0; r < 4; r++) begin
          ovf_nx = ovf_nx | rr[r].ovf;
        end
      end
      OP_CONJ: begin
        for (int r = 0; r < 3; r++) begin
          res_nx[r] = rneg[r].v;
          ovf_nx    = ovf_nx | rneg[r].ovf;
        end
        res_nx[3] = s1_a[3];
      end
      OP_ADD: begin
        for (int r = 0; r < 4; r++) begin
          res_nx[r] = radd[r].v;
          ovf_nx    = ovf_nx | radd[r].ovf;
        end
      end
      OP_SCALE: begin
        for (int r = 0; r < 4; r++) begin
          res_nx[r] = rsc[r].v;
          ovf_nx    = ovf_nx | rsc[r].ovf;
        end
      end
      OP_DOT: begin
        res_nx[3] = rdot.v;
        ovf_nx    = rdot.ovf;
      end
      default: ;
    endcase
  end

  opcode_t            s2_op;
  comp_t              s2_res [4];
  logic               s2_ovf;
  logic               s2_zdiv;
  comp_t              s2_t [4];
  logic signed [CW:0] s2_cj [4];
  logic [CW-1:0]      s2_mag [4];
  logic [3:0]         s2_neg;
  logic [NW-1:0]      s2_n;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_op   <= s1_op;
      s2_res  <= res_nx;
      s2_ovf  <= ovf_nx;
      s2_zdiv <= (s1_op == OP_INV) &&
                 ((NW+CFG_W)'(n_nx) <= (NW+CFG_W)'(min_norm_sq));
      s2_n    <= n_nx;
      for (int c = 0; c < 4; c++) begin
        s2_t[c]   <= rr[c].v;
        s2_cj[c]  <= cv[c];
        s2_neg[c] <= cv[c][CW];
        s2_mag[c] <= cv[c][CW] ? CW'(-cv[c]) : CW'(cv[c]);
      end
    end
  end

  // ---------------- divider stages; rotation second product rides along
  comp_t dq [4];
  logic  dq_ovf;

  qau_div_pipe u_div (
    .clk  (clk),
    .en   (adv[DIV_ST+2:2]),
    .mag  (s2_mag),
    .neg  (s2_neg),
    .n    (s2_n),
    .quot (dq),
    .ovf  (dq_ovf)
  );

  opcode_t               sb_op   [DIV_ST+1];
  comp_t                 sb_res  [DIV_ST+1][4];
  logic                  sb_ovf  [DIV_ST+1];
  logic                  sb_zdiv [DIV_ST+1];
  logic signed [P2W-1:0] rx [3][4];

  logic signed [SW-1:0] sx [3];
  sat_t                 rw [3];
  logic                 rot_ovf;

  always_comb begin
    rot_ovf = 1'b0;
    for (int r = 0; r < 3; r++) begin
      sx[r] = '0;
      for (int c = 0; c < 4; c++) begin
        if (HP_NEG[r][c]) begin
          sx[r] = sx[r] - ext_x(rx[r][c]);
        end else begin
          sx[r] = sx[r] + ext_x(rx[r][c]);
        end
      end
      rw[r]   = round_sat(sx[r]);
      rot_ovf = rot_ovf | rw[r].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sb_op[0]   <= s2_op;
      sb_res[0]  <= s2_res;
      sb_ovf[0]  <= s2_ovf;
      sb_zdiv[0] <= s2_zdiv;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          rx[r][c] <= s2_t[c] * s2_cj[HP_PICK[r][c]];
        end
      end
    end
    if (adv[3]) begin
      sb_op[1]   <= sb_op[0];
      sb_zdiv[1] <= sb_zdiv[0];
      if (sb_op[0] == OP_ROT) begin
        sb_res[1] <= '{rw[0].v, rw[1].v, rw[2].v, '0};
        sb_ovf[1] <= sb_ovf[0] | rot_ovf;
      end else begin
        sb_res[1] <= sb_res[0];
        sb_ovf[1] <= sb_ovf[0];
      end
    end
    for (int d = 2; d <= DIV_ST; d++) begin
      if (adv[d+2]) begin
        sb_op[d]   <= sb_op[d-1];
        sb_res[d]  <= sb_res[d-1];
        sb_ovf[d]  <= sb_ovf[d-1];
        sb_zdiv[d] <= sb_zdiv[d-1];
      end
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      if (sb_op[DIV_ST] == OP_INV) begin
        if (sb_zdiv[DIV_ST]) begin
          rsp <= '{res_i: '0, res_j: '0, res_k: '0, res_r: '0, status: ST_ZDIV};
        end else begin
          rsp <= '{res_i: dq[0], res_j: dq[1], res_k: dq[2], res_r: dq[3],
                   status: dq_ovf ? ST_OVF : ST_OK};
        end
      end else begin
        rsp <= '{res_i: sb_res[DIV_ST][0], res_j: sb_res[DIV_ST][1],
                 res_k: sb_res[DIV_ST][2], res_r: sb_res[DIV_ST][3],
                 status: sb_ovf[DIV_ST] ? ST_OVF : ST_OK};
      end
    end
  end

  // ---------------- checks
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
      cmd_stall |-> (&vld))
    else $error("cmd stalled with a bubble in the pipe");

  a_zdiv_zero: assert property (@(posedge clk) disable iff (rst)
      (rsp_valid && rsp.status == ST_ZDIV) |->
      (rsp.res_i == '0 && rsp.res_j == '0 && rsp.res_k == '0 && rsp.res_r == '0))
    else $error("zero divisor result not cleared");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (vld[NST-2] && !adv[NST-2]) |=> vld[NST-2])
    else $error("last divider stage dropped a transaction");

endmodule

`default_nettype wire
